// File: sv/bmr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the Belady MIN replacement block.
package bmr_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned NU_W   = 48;
  localparam int unsigned USED_W = 33;
  localparam int unsigned CAP_W  = 32;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 32'd65536;

  localparam logic KIND_OUTCOME  = 1'b0;
  localparam logic KIND_EVICTION = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  req_key;
    logic [SIZE_W-1:0] req_size;
    logic [NU_W-1:0]   next_use;
  } bmr_req_t;

  typedef struct packed {
    logic             result_kind;
    logic             was_hit;
    logic [KEY_W-1:0] victim_key;
    logic             last_result;
  } bmr_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MSCAN,
    ST_MUPD,
    ST_MOUT,
    ST_ESCAN,
    ST_EUPD,
    ST_EOUT
  } bmr_state_e;

  typedef struct packed {
    logic clr_en;
    logic ld_req;
    logic scan_start;
    logic scan_run;
    logic ins_wr;
    logic ev_wr;
    logic out_load;
    logic out_kind;
    logic out_last;
  } bmr_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic hit;
    logic evict_more;
    logic out_free;
  } bmr_sts_t;

endpackage

// File: sv/belady_min_replacement.sv
`timescale 1ns / 1ps
// Top level of the size-aware Belady MIN replacement block.
//
// The block holds up to ENTRIES objects in one slot memory and handles one access at a time.
// Every access gives an outcome item first and then one eviction item per victim, the farthest
// next use going first and ties to the lowest slot. Each pass over the slots reads the memory
// through its single read port, one slot per cycle, and a miss makes one more pass per eviction.
// After reset the block clears every slot of the memory and stalls its input until that is done.
// The capacity register answers at every address with paddr[2] low and resets to 65536 bytes.
module belady_min_replacement #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned POS_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bmr_pkg::bmr_req_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bmr_pkg::bmr_rsp_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmr_pkg::PADDR_W-1:0]   paddr,
  input  logic [bmr_pkg::PDATA_W-1:0]   pwdata,
  output logic [bmr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bmr_pkg::*;

  logic [CAP_W-1:0] capacity_q, capacity_d;
  logic             cfg_hit;
  bmr_cmd_t         cmd;
  bmr_sts_t         sts;

  assign pready  = 1'b1;
  assign cfg_hit = paddr[PADDR_W-1] == REG_CAPACITY;
  assign prdata  = cfg_hit ? capacity_q : '0;

  always_comb begin
    capacity_d = capacity_q;
    if (psel && penable && pwrite && pready && cfg_hit) begin
      capacity_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  bmr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bmr_dpath #(
    .ENTRIES (ENTRIES),
    .POS_BITS(POS_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_i      (in_data_i),
    .capacity_i (capacity_q),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

// File: sv/bmr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bmr_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences clearing, scans, updates and results.
module bmr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bmr_pkg::bmr_sts_t sts_i,
  output bmr_pkg::bmr_cmd_t cmd_o
);
  import bmr_pkg::*;

  bmr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clr_done) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_MSCAN;
      ST_MSCAN: if (sts_i.scan_done) state_d = ST_MUPD;
      ST_MUPD:  state_d = ST_MOUT;
      ST_MOUT: begin
        if (sts_i.out_free) begin
          state_d = (sts_i.hit || !sts_i.evict_more) ? ST_IDLE : ST_ESCAN;
        end
      end
      ST_ESCAN: if (sts_i.scan_done) state_d = ST_EUPD;
      ST_EUPD:  state_d = ST_EOUT;
      ST_EOUT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.evict_more ? ST_ESCAN : ST_IDLE;
        end
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.ld_req     = in_valid_i;
        cmd_o.scan_start = in_valid_i;
      end
      ST_MSCAN: cmd_o.scan_run = 1'b1;
      ST_MUPD:  cmd_o.ins_wr = 1'b1;
      ST_MOUT: begin
        cmd_o.out_load   = sts_i.out_free;
        cmd_o.out_kind   = KIND_OUTCOME;
        cmd_o.out_last   = sts_i.hit || !sts_i.evict_more;
        cmd_o.scan_start = sts_i.out_free && !sts_i.hit && sts_i.evict_more;
      end
      ST_ESCAN: cmd_o.scan_run = 1'b1;
      ST_EUPD:  cmd_o.ev_wr = 1'b1;
      ST_EOUT: begin
        cmd_o.out_load   = sts_i.out_free;
        cmd_o.out_kind   = KIND_EVICTION;
        cmd_o.out_last   = !sts_i.evict_more;
        cmd_o.scan_start = sts_i.out_free && sts_i.evict_more;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: sv/bmr_dpath.sv
`timescale 1ns / 1ps
// Datapath with the slot memory, scan trackers, byte and slot counters and result register.
module bmr_dpath #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned POS_BITS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bmr_pkg::bmr_cmd_t               cmd_i,
  output bmr_pkg::bmr_sts_t               sts_o,
  input  bmr_pkg::bmr_req_t               req_i,
  input  logic [bmr_pkg::CAP_W-1:0]       capacity_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output bmr_pkg::bmr_rsp_t               out_data_o
);
  import bmr_pkg::*;

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned WORD_W = 1 + KEY_W + SIZE_W + POS_BITS;

  logic [KEY_W-1:0]    key_q, key_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [POS_BITS-1:0] nu_q, nu_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [63:0]         nu_ext;

  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [SIZE_W-1:0] hit_size_q, hit_size_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             vic_q, vic_d;
  logic [IDX_W-1:0] vic_idx_q, vic_idx_d;
  logic [KEY_W-1:0] vic_key_q, vic_key_d;
  logic [SIZE_W-1:0] vic_size_q, vic_size_d;
  logic [POS_BITS-1:0] vic_nu_q, vic_nu_d;

  logic [USED_W-1:0] used_q, used_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic     out_valid_q, out_valid_d;
  bmr_rsp_t out_q, out_d;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;
  logic [WORD_W-1:0] rdata;

  logic                d_valid;
  logic [KEY_W-1:0]    d_key;
  logic [SIZE_W-1:0]   d_size;
  logic [POS_BITS-1:0] d_nu;

  bmr_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign d_valid = rdata[WORD_W-1];
  assign d_key   = rdata[WORD_W-2 -: KEY_W];
  assign d_size  = rdata[POS_BITS+SIZE_W-1 -: SIZE_W];
  assign d_nu    = rdata[POS_BITS-1:0];

  assign nu_ext = {{(64 - NU_W){1'b0}}, req_i.next_use};
  assign raddr  = rd_cnt_q[IDX_W-1:0];

  always_comb begin
    key_d  = key_q;
    size_d = size_q;
    nu_d   = nu_q;
    pos_d  = pos_q;
    if (cmd_i.ld_req) begin
      key_d  = req_i.req_key;
      size_d = req_i.req_size;
      nu_d   = nu_ext[POS_BITS-1:0];
      pos_d  = pos_q + POS_BITS'(1);
    end
  end

  always_comb begin
    rd_cnt_d  = rd_cnt_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    if (cmd_i.scan_start) begin
      rd_cnt_d = '0;
    end else if (cmd_i.scan_run && (rd_cnt_q < CNT_W'(ENTRIES))) begin
      rd_cnt_d  = rd_cnt_q + CNT_W'(1);
      cmp_vld_d = 1'b1;
      cmp_idx_d = rd_cnt_q[IDX_W-1:0];
    end
  end

  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_size_d = hit_size_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    vic_d      = vic_q;
    vic_idx_d  = vic_idx_q;
    vic_key_d  = vic_key_q;
    vic_size_d = vic_size_q;
    vic_nu_d   = vic_nu_q;
    if (cmd_i.scan_start) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
      vic_d  = 1'b0;
    end else if (cmp_vld_q) begin
      if (d_valid && (d_key == key_q) && !hit_q) begin
        hit_d      = 1'b1;
        hit_idx_d  = cmp_idx_q;
        hit_size_d = d_size;
      end
      if (!d_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
      if (d_valid && (!vic_q || (d_nu > vic_nu_q))) begin
        vic_d      = 1'b1;
        vic_idx_d  = cmp_idx_q;
        vic_key_d  = d_key;
        vic_size_d = d_size;
        vic_nu_d   = d_nu;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    clr_d = clr_q;
    priority if (cmd_i.clr_en) begin
      we    = 1'b1;
      clr_d = clr_q + IDX_W'(1);
    end else if (cmd_i.ins_wr) begin
      we    = 1'b1;
      waddr = hit_q ? hit_idx_q : free_idx_q;
      wdata = {1'b1, key_q, (hit_q ? hit_size_q : size_q), nu_q};
    end else if (cmd_i.ev_wr) begin
      we    = vic_q;
      waddr = vic_idx_q;
      wdata = {1'b0, vic_key_q, vic_size_q, vic_nu_q};
    end
  end

  always_comb begin
    used_d  = used_q;
    count_d = count_q;
    if (cmd_i.ins_wr && !hit_q) begin
      used_d  = used_q + {1'b0, size_q};
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.ev_wr) begin
      if (vic_q) begin
        used_d  = (used_q >= {1'b0, vic_size_q}) ? (used_q - {1'b0, vic_size_q}) : '0;
        count_d = count_q - CNT_W'(1);
      end else begin
        used_d = '0;
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.out_load) begin
      out_valid_d       = 1'b1;
      out_d.result_kind = cmd_i.out_kind;
      out_d.was_hit     = (cmd_i.out_kind == KIND_OUTCOME) && hit_q;
      out_d.victim_key  = (cmd_i.out_kind == KIND_EVICTION) ? vic_key_q : '0;
      out_d.last_result = cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rd_cnt_q    <= '0;
      cmp_vld_q   <= 1'b0;
      clr_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      vic_q       <= 1'b0;
      used_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      rd_cnt_q    <= rd_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      clr_q       <= clr_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      vic_q       <= vic_d;
      used_q      <= used_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    size_q     <= size_d;
    nu_q       <= nu_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_size_q <= hit_size_d;
    free_idx_q <= free_idx_d;
    vic_idx_q  <= vic_idx_d;
    vic_key_q  <= vic_key_d;
    vic_size_q <= vic_size_d;
    vic_nu_q   <= vic_nu_d;
    out_q      <= out_d;
  end

  assign sts_o.clr_done   = clr_q == IDX_W'(ENTRIES - 1);
  assign sts_o.scan_done  = cmp_vld_q && (cmp_idx_q == IDX_W'(ENTRIES - 1));
  assign sts_o.hit        = hit_q;
  assign sts_o.evict_more = (used_q > {1'b0, capacity_i}) || (count_q == CNT_W'(ENTRIES));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/bmr_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the replacement block and their binding to the top level.
module bmr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input bmr_pkg::bmr_rsp_t out_data_o
);
  import bmr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("Stalled result item changed or dropped.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Input taken again right after an accepted item.");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last_result) |-> in_stall_o)
    else $error("New item accepted before the last result of the previous one.");

  a_hit_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.result_kind == KIND_OUTCOME) && out_data_o.was_hit)
      |-> (out_data_o.last_result && (out_data_o.victim_key == '0)))
    else $error("Hit outcome item not final or carries a victim.");

endmodule

bind belady_min_replacement bmr_checker u_bmr_checker (.*);

// File: tb/tb_belady_min_replacement.sv
`timescale 1ns / 1ps
// Self-checking testbench of the size-aware Belady MIN replacement block.
module tb_belady_min_replacement;
  import bmr_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned DIR_ROWS = 23;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned N_PHASES = 6;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
  localparam logic [NU_W-1:0] NEVER = {NU_W{1'b1}};

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [SIZE_W-1:0]      size;
    logic [NU_W-1:0]        nu;
    logic                   typed;
    logic                   t_hit;
    logic [1:0]             t_nev;
    logic [2:0][KEY_W-1:0]  t_vic;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{32'h0000_0000, 32'd1,         48'd5, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h0000_0000, 32'd1,         48'd9, 1'b1, 1'b1, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'hFFFF_FFFF, 32'd100,       NEVER, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h0000_0001, 32'hFFFF_FFFF, 48'd3, 1'b1, 1'b0, 2'd3,
      {32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF}},
    '{32'h10, 32'd16, 48'd200, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h11, 32'd16, 48'd201, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h12, 32'd16, 48'd202, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h13, 32'd16, NEVER,   1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h14, 32'd16, 48'd204, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h15, 32'd16, 48'd205, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h16, 32'd16, 48'd206, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h17, 32'd16, NEVER,   1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h18, 32'd16, 48'd208, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h19, 32'd16, 48'd209, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h1A, 32'd16, 48'd210, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h1B, 32'd16, 48'd211, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h1C, 32'd16, 48'd212, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h1D, 32'd16, 48'd213, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h1E, 32'd16, 48'd214, 1'b1, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h20, 32'd16, 48'd50,  1'b1, 1'b0, 2'd1, {32'h0, 32'h0, 32'h13}},
    '{32'h21, 32'd16, 48'd60,  1'b1, 1'b0, 2'd1, {32'h0, 32'h0, 32'h17}},
    '{32'h14, 32'd16, 48'd1,   1'b1, 1'b1, 2'd0, {32'h0, 32'h0, 32'h0}},
    '{32'h22, 32'd65536, 48'd10, 1'b0, 1'b0, 2'd0, {32'h0, 32'h0, 32'h0}}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  bmr_req_t          in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  bmr_rsp_t          out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic              pready;

  logic              slot_live [SLOTS];
  logic [KEY_W-1:0]  slot_key [SLOTS];
  logic [SIZE_W-1:0] slot_size [SLOTS];
  logic [NU_W-1:0]   slot_nu [SLOTS];
  logic [63:0]       bytes_used = '0;
  logic [CAP_W-1:0]  cap_bytes = CAPACITY_RESET;

  bmr_rsp_t          owed_rsp [$];
  int unsigned       n_bad = 0;
  int unsigned       burst_left = 0;
  logic [NU_W-1:0]   trace_pos = '0;
  logic              hold_flip = 1'b0;
  logic              hold_seen = 1'b0;
  int unsigned       hold_left = 0;
  logic [7:0]        stall_pat = '0;
  int unsigned       pat_age = 0;

  belady_min_replacement #(
    .ENTRIES (SLOTS),
    .POS_BITS(NU_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("belady_min_replacement: mismatch");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (n_bad < 50) begin
      $display("ERROR at %0t: %s got %0h, expected %0h", $time, what, got, want);
    end
    n_bad++;
  endtask

  function automatic bmr_rsp_t rsp_of(input logic kind, input logic hit,
                                      input logic [KEY_W-1:0] key);
    bmr_rsp_t r;
    r.result_kind = kind;
    r.was_hit = hit;
    r.victim_key = key;
    r.last_result = 1'b0;
    return r;
  endfunction

  task automatic predict_access(input bmr_req_t r, input bit keep);
    int hit_slot;
    int victim;
    int n_live;
    bit placed;
    bmr_rsp_t res [$];
    hit_slot = -1;
    placed = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_slot < 0 && slot_live[i] && slot_key[i] == r.req_key) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      slot_nu[hit_slot] = r.next_use;
      res = {res, rsp_of(KIND_OUTCOME, 1'b1, '0)};
    end else begin
      res = {res, rsp_of(KIND_OUTCOME, 1'b0, '0)};
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !slot_live[i]) begin
          placed = 1'b1;
          slot_live[i] = 1'b1;
          slot_key[i] = r.req_key;
          slot_size[i] = r.req_size;
          slot_nu[i] = r.next_use;
          bytes_used = bytes_used + {32'b0, r.req_size};
        end
      end
      forever begin
        n_live = 0;
        for (int i = 0; i < SLOTS; i++) n_live += int'(slot_live[i]);
        if (!(bytes_used > {32'b0, cap_bytes} || n_live >= SLOTS)) break;
        victim = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && (victim < 0 || slot_nu[i] > slot_nu[victim])) victim = i;
        end
        if (victim < 0) begin
          bytes_used = '0;
          break;
        end
        slot_live[victim] = 1'b0;
        if (bytes_used >= {32'b0, slot_size[victim]}) begin
          bytes_used = bytes_used - {32'b0, slot_size[victim]};
        end else begin
          bytes_used = '0;
        end
        res = {res, rsp_of(KIND_EVICTION, 1'b0, slot_key[victim])};
      end
    end
    res[res.size()-1].last_result = 1'b1;
    if (keep) begin
      owed_rsp = {owed_rsp, res};
    end
  endtask

  function automatic bmr_req_t rand_access();
    bmr_req_t r;
    int unsigned pick;
    logic [31:0] ceil_sz;
    pick = $urandom_range(0, 99);
    if (pick < 70) r.req_key = $urandom_range(0, 19);
    else if (pick < 85) r.req_key = 32'hFFFF_FFFF - $urandom_range(0, 7);
    else r.req_key = $urandom;
    ceil_sz = cap_bytes / 5 + 1;
    pick = $urandom_range(0, 99);
    if (pick < 8) r.req_size = $urandom;
    else if (pick < 11) r.req_size = '1;
    else r.req_size = $urandom_range(1, ceil_sz);
    if (r.req_size == '0) r.req_size = 1;
    pick = $urandom_range(0, 99);
    if (pick < 15) r.next_use = NEVER;
    else if (pick < 25) r.next_use = NU_W'({$urandom, $urandom});
    else r.next_use = trace_pos + NU_W'($urandom_range(1, 40));
    return r;
  endfunction

  task automatic offer(input bmr_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    trace_pos = trace_pos + 1'b1;
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (owed_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CAP_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_bytes = v;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== v) flag_mismatch("capacity readback", 64'(prdata), 64'(v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    bmr_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_rsp.size() == 0) begin
        flag_mismatch("result with no item pending", 64'(out_data_o), '0);
      end else begin
        want = owed_rsp.pop_front();
        if (out_data_o.result_kind !== want.result_kind)
          flag_mismatch("result_kind", 64'(out_data_o.result_kind), 64'(want.result_kind));
        if (out_data_o.was_hit !== want.was_hit)
          flag_mismatch("was_hit", 64'(out_data_o.was_hit), 64'(want.was_hit));
        if (out_data_o.victim_key !== want.victim_key)
          flag_mismatch("victim_key", 64'(out_data_o.victim_key), 64'(want.victim_key));
        if (out_data_o.last_result !== want.last_result)
          flag_mismatch("last_result", 64'(out_data_o.last_result), 64'(want.last_result));
      end
    end
    if (hold_seen != hold_flip) begin
      hold_seen = hold_flip;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (pat_age == 0) begin
        pat_age = $urandom_range(16, 96);
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'h00 : (8'($urandom) & 8'hEF);
      end
      pat_age--;
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      out_stall_i <= stall_pat[0];
    end
  end

  initial begin
    bmr_req_t r;
    logic [CAP_W-1:0] phase_cap [N_PHASES];
    phase_cap = '{32'd1000, 32'hFFFF_FFFF, 32'd1, 32'd4096, 32'd0, 32'd65536};
    phase_cap[4] = $urandom_range(200, 100000);
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_key[i] = '0;
      slot_size[i] = '0;
      slot_nu[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      r.req_key = DIR_TAB[i].key;
      r.req_size = DIR_TAB[i].size;
      r.next_use = DIR_TAB[i].nu;
      offer(r);
      predict_access(r, !DIR_TAB[i].typed);
      if (DIR_TAB[i].typed) begin
        owed_rsp = {owed_rsp, rsp_of(KIND_OUTCOME, DIR_TAB[i].t_hit, '0)};
        for (int k = 0; k < int'(DIR_TAB[i].t_nev); k++) begin
          owed_rsp = {owed_rsp, rsp_of(KIND_EVICTION, 1'b0, DIR_TAB[i].t_vic[k])};
        end
        owed_rsp[owed_rsp.size()-1].last_result = 1'b1;
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      cfg_write(phase_cap[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = rand_access();
        offer(r);
        predict_access(r, 1'b1);
        if (p == 0 && n == 30) hold_flip <= ~hold_flip;
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("belady_min_replacement: match");
    end else begin
      $display("belady_min_replacement: mismatch");
    end
    $finish;
  end

endmodule
